// ===== design/wra_pkg.sv =====
// Shared types and constants for the weighted running average filter.
// No dependencies; compile this file first.
package wra_pkg;

	// Weight register width and the configuration port geometry.
	localparam int WEIGHT_W    = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FILTER_WEIGHT = 1'b0,
		REG_SEED_ON_ZERO  = 1'b1
	} cfg_reg_t;

	// Sequencer states, one-hot encoded.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ADD  = 7'b0000100,
		ST_ABS  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FIX  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

// ===== design/wra_stream_if.sv =====
// Valid/ready stream interfaces for the sample input and the average output.
// No dependencies; compile after wra_pkg.
interface wra_sample_if #(parameter int SAMPLE_WIDTH = 32);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] new_sample;

	modport source (output valid, output new_sample, input ready);
	modport sink   (input valid, input new_sample, output ready);
endinterface

interface wra_value_if #(parameter int SAMPLE_WIDTH = 32);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink   (input valid, input filtered_value, output ready);
endinterface

// ===== design/weighted_running_average.sv =====
// Weighted running average: avg <= (avg*N + sample)/(N+1), truncated toward zero.
// The sample passes through a multiply, an add, an absolute value, a restoring divider that
// retires one quotient bit per cycle over SAMPLE_WIDTH+17 bits, a sign fix and a hand-off
// state. A new sample is taken only after the previous result is handed to the output;
// pass-through samples skip straight to the hand-off state.
// Reset (arst_n low, asynchronous) clears the average, both registers and the output valid.
module weighted_running_average
	import wra_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	wra_sample_if.sink             samples,
	wra_value_if.source            averages
);

	localparam int ACC_W = SAMPLE_WIDTH + WEIGHT_W + 1;
	localparam int CNT_W = $clog2(ACC_W);
	localparam int REM_W = WEIGHT_W + 2;

	state_t                         state_q;
	logic [WEIGHT_W-1:0]            weight_q;
	logic                           seed_q;
	logic signed [SAMPLE_WIDTH-1:0] avg_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_data_q;
	logic signed [SAMPLE_WIDTH-1:0] smp_q;
	logic signed [SAMPLE_WIDTH-1:0] result_q;
	logic [ACC_W-1:0]               dvd_q;
	logic [WEIGHT_W:0]              div_q;
	logic [REM_W-1:0]               rem_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           neg_q;

	logic                           in_xfer;
	logic                           bypass;
	logic                           load_out;
	logic signed [ACC_W-1:0]        prod_w;
	logic signed [ACC_W-1:0]        smp_ext;
	logic [REM_W-1:0]               rem_sh;
	logic                           quo_bit;

	// Handshake and pass-through decision.
	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign bypass        = (weight_q == '0) || (seed_q && (avg_q == '0));
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || averages.ready);

	assign averages.valid          = out_valid_q;
	assign averages.filtered_value = out_data_q;

	// Datapath: the multiplier and one divider step.
	always_comb begin
		prod_w  = $signed(avg_q) * $signed({1'b0, weight_q});
		smp_ext = ACC_W'(smp_q);
		rem_sh  = {rem_q[REM_W-2:0], dvd_q[ACC_W-1]};
		quo_bit = (rem_sh >= REM_W'(div_q));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			seed_q   <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FILTER_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_SEED_ON_ZERO:  seed_q   <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Sequencer, stored average and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				avg_q       <= result_q;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= bypass ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX:  state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: product, dividend/quotient shifter, remainder and result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					smp_q    <= samples.new_sample;
					result_q <= samples.new_sample;
					div_q    <= {1'b0, weight_q} + (WEIGHT_W + 1)'(1);
				end
			end
			ST_MUL: dvd_q <= prod_w;
			ST_ADD: dvd_q <= $signed(dvd_q) + smp_ext;
			ST_ABS: begin
				neg_q <= dvd_q[ACC_W-1];
				dvd_q <= dvd_q[ACC_W-1] ? (~dvd_q + ACC_W'(1)) : dvd_q;
				rem_q <= '0;
				cnt_q <= CNT_W'(ACC_W - 1);
			end
			ST_DIV: begin
				// Restoring division: one quotient bit shifts in at the bottom.
				rem_q <= quo_bit ? (rem_sh - REM_W'(div_q)) : rem_sh;
				dvd_q <= {dvd_q[ACC_W-2:0], quo_bit};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_FIX: begin
				result_q <= neg_q ? (~dvd_q[SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1))
				                  : dvd_q[SAMPLE_WIDTH-1:0];
			end
			ST_DONE: begin
				if (load_out) begin
					out_data_q <= result_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/wra_checker.sv =====
// Port-level assertions for the weighted running average filter, bound to its top level.
// Depends on wra_pkg and weighted_running_average.
module wra_checker
	import wra_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_write_en,
	input logic [CFG_INDEX_W-1:0]         cfg_index,
	input logic [CFG_DATA_W-1:0]          cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] out_value
);

	logic weight_zero_q;
	logic rst_seen_q;

	// Shadow of whether the weight register currently holds zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_zero_q <= 1'b1;
		end else if (cfg_write_en && (cfg_index == REG_FILTER_WEIGHT)) begin
			weight_zero_q <= (cfg_data[WEIGHT_W-1:0] == '0);
		end
	end

	// Reset level seen at the previous clock edge, so the first edge is not judged.
	always_ff @(posedge clk) begin
		rst_seen_q <= !arst_n;
	end

	// Reset leaves the output empty and the input open.
	a_reset_state: assert property (@(posedge clk)
		(!arst_n && rst_seen_q) |-> (!out_valid && in_ready))
		else $error("output valid or input stalled during reset");

	// One sample at a time: the input closes after each transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted a second sample while busy");

	// With zero weight the sample passes through the done state into the output register unchanged.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && weight_zero_q && !out_valid) |=>
		##1 (out_valid && (out_value == $past(in_sample, 2))))
		else $error("pass-through sample not returned unchanged");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
		else $error("stalled result dropped or changed");

endmodule

bind weighted_running_average wra_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_wra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_write_en (cfg_write_en),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.in_sample    (samples.new_sample),
	.out_valid    (averages.valid),
	.out_ready    (averages.ready),
	.out_value    (averages.filtered_value)
);

// ===== sim/weighted_running_average_tb.sv =====
// Self-checking testbench for the weighted running average filter.
// Depends on wra_pkg, the stream interfaces in wra_stream_if.sv and the filter RTL.
`timescale 1ns / 100ps

module weighted_running_average_tb;
	import wra_pkg::*;

	localparam int SAMPLE_WIDTH  = 32;
	localparam int RANDOM_ITEMS  = 750;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int REPORT_LIMIT  = 10;

	// One directed row: register settings, the sample, and optionally a known average.
	typedef struct packed {
		logic [15:0] weight;
		logic [15:0] seed_raw;
		logic [31:0] sample;
		logic        known;
		logic [31:0] value;
	} vector_row_t;

	localparam int DIRECTED_COUNT = 25;
	localparam vector_row_t DIRECTED [DIRECTED_COUNT] = '{
		// Reset weight of zero passes the extremes straight through.
		'{16'h0000, 16'h0000, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
		'{16'h0000, 16'h0000, 32'h80000000, 1'b1, 32'h80000000},
		'{16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000},
		// Seeding from a zero average; only bit 0 of the seed register counts.
		'{16'h0003, 16'hFFFF, 32'h000004D2, 1'b1, 32'h000004D2},
		'{16'h0003, 16'hFFFF, 32'hFFFFFC18, 1'b0, 32'h00000000},
		'{16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000},
		'{16'h0003, 16'hFFFE, 32'h000003E8, 1'b0, 32'h00000000},
		// Largest weight against the sample extremes.
		'{16'hFFFF, 16'h0000, 32'h7FFFFFFF, 1'b0, 32'h00000000},
		'{16'hFFFF, 16'h0000, 32'h7FFFFFFF, 1'b0, 32'h00000000},
		'{16'hFFFF, 16'h0000, 32'h80000000, 1'b0, 32'h00000000},
		'{16'h0000, 16'h0000, 32'h80000000, 1'b1, 32'h80000000},
		'{16'hFFFF, 16'h0000, 32'h7FFFFFFF, 1'b0, 32'h00000000},
		'{16'hFFFF, 16'h0001, 32'h80000000, 1'b0, 32'h00000000},
		// Small values where truncation toward zero matters.
		'{16'h0001, 16'h0000, 32'hFFFFFFFD, 1'b0, 32'h00000000},
		'{16'h0001, 16'h0000, 32'h00000004, 1'b0, 32'h00000000},
		'{16'h0002, 16'h0001, 32'hFFFFFFF9, 1'b0, 32'h00000000},
		'{16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{16'h0001, 16'h0000, 32'h00000000, 1'b0, 32'h00000000},
		'{16'h0001, 16'h0001, 32'h00000002, 1'b1, 32'h00000002},
		// Alternating bit patterns.
		'{16'h0001, 16'h0000, 32'h55555555, 1'b0, 32'h00000000},
		'{16'h0001, 16'h0000, 32'hAAAAAAAA, 1'b0, 32'h00000000},
		'{16'h0002, 16'h0000, 32'h00000001, 1'b0, 32'h00000000},
		'{16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000},
		'{16'hFFFF, 16'h0001, 32'h00000000, 1'b0, 32'h00000000}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	wra_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples ();
	wra_value_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) averages ();

	weighted_running_average #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.samples      (samples),
		.averages     (averages)
	);

	// Filter state mirrored on the testbench side.
	logic signed [SAMPLE_WIDTH-1:0] model_average;
	logic [WEIGHT_W-1:0]            model_weight;
	logic                           model_seed;
	logic [CFG_DATA_W-1:0]          last_seed_raw;

	logic signed [SAMPLE_WIDTH-1:0] pending_averages [$];

	bit no_idle;
	int mismatches;
	int averages_checked;
	int samples_sent;
	int settings_used;
	int pass_through_count;
	int seeded_count;
	int weighted_count;
	int idle_cycles;

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fold one sample into the mirrored average and return the new value.
	function automatic logic signed [SAMPLE_WIDTH-1:0] next_average(
			input logic signed [SAMPLE_WIDTH-1:0] value);
		longint acc;
		longint weight_l;
		longint average_l;
		weight_l  = model_weight;
		average_l = model_average;
		if (model_weight == 0) begin
			pass_through_count++;
			model_average = value;
		end else if (model_seed && model_average == 0) begin
			seeded_count++;
			model_average = value;
		end else begin
			weighted_count++;
			acc = average_l * weight_l + longint'(value);
			model_average = SAMPLE_WIDTH'(acc / (weight_l + 1));
		end
		return model_average;
	endfunction

	// Offer one sample after a random gap and record its expected average on transfer.
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value, input logic known,
			input logic signed [SAMPLE_WIDTH-1:0] known_value);
		int gap;
		logic signed [SAMPLE_WIDTH-1:0] predicted;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid      <= 1'b1;
		samples.new_sample <= value;
		do @(posedge clk); while (!(samples.valid && samples.ready));
		predicted = next_average(value);
		pending_averages.push_back(known ? known_value : predicted);
		samples_sent++;
	endtask

	// Stop offering samples and wait for every outstanding average to come back.
	task automatic drain_averages();
		samples.valid <= 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Write both registers on consecutive edges while the filter is idle.
	task automatic write_settings(input logic [CFG_DATA_W-1:0] weight,
			input logic [CFG_DATA_W-1:0] seed_raw);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_FILTER_WEIGHT;
		cfg_data     <= weight;
		@(posedge clk);
		cfg_index    <= REG_SEED_ON_ZERO;
		cfg_data     <= seed_raw;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		model_weight  = weight[WEIGHT_W-1:0];
		model_seed    = seed_raw[0];
		last_seed_raw = seed_raw;
		settings_used++;
	endtask

	// Result side: random stalls on ready, and each transfer compared with the oldest expectation.
	initial begin : average_sink
		int stall;
		logic signed [SAMPLE_WIDTH-1:0] wanted;
		averages.ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				averages.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			averages.ready <= 1'b1;
			do @(posedge clk); while (!(averages.valid && averages.ready));
			if (pending_averages.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: unexpected average %0d at %0t",
						averages.filtered_value, $realtime);
			end else begin
				wanted = pending_averages.pop_front();
				averages_checked++;
				if (averages.filtered_value !== wanted) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("ERROR: filtered_value expected %0d, got %0d at %0t",
							wanted, averages.filtered_value, $realtime);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer or register write.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || cfg_write_en || (samples.valid && samples.ready)
				|| (averages.valid && averages.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles at %0t", IDLE_LIMIT, $realtime);
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random register settings and samples.
	initial begin : stimulus
		int phase_len;
		int random_sent;
		logic [CFG_DATA_W-1:0] weight;
		logic signed [SAMPLE_WIDTH-1:0] value;

		arst_n             = 1'b0;
		cfg_write_en       = 1'b0;
		cfg_index          = REG_FILTER_WEIGHT;
		cfg_data           = '0;
		samples.valid      = 1'b0;
		samples.new_sample = '0;
		model_average      = '0;
		model_weight       = '0;
		model_seed         = 1'b0;
		last_seed_raw      = '0;
		no_idle            = 1'b0;
		mismatches         = 0;
		averages_checked   = 0;
		samples_sent       = 0;
		settings_used      = 0;
		pass_through_count = 0;
		seeded_count       = 0;
		weighted_count     = 0;
		random_sent        = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; registers are rewritten only when a row changes them.
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			if (DIRECTED[i].weight != model_weight || DIRECTED[i].seed_raw != last_seed_raw) begin
				drain_averages();
				write_settings(DIRECTED[i].weight, DIRECTED[i].seed_raw);
			end
			send_sample(DIRECTED[i].sample, DIRECTED[i].known, DIRECTED[i].value);
		end

		// Random phases, each with its own settings written after a full drain.
		while (random_sent < RANDOM_ITEMS) begin
			drain_averages();
			case ($urandom_range(0, 6))
				0:       weight = 16'h0000;
				1:       weight = 16'h0001;
				2:       weight = 16'hFFFF;
				3:       weight = 16'hFFFE;
				4:       weight = CFG_DATA_W'($urandom_range(2, 15));
				default: weight = CFG_DATA_W'($urandom_range(0, 65535));
			endcase
			write_settings(weight, CFG_DATA_W'($urandom_range(0, 65535)));
			no_idle   = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(10, 60);
			for (int k = 0; k < phase_len; k++) begin
				case ($urandom_range(0, 6))
					0:       value = int'($urandom_range(0, 6)) - 3;
					1:       value = '0;
					2:       value = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
					3:       value = 32'h7FFFFFFF - $urandom_range(0, 255);
					4:       value = 32'h80000000 + $urandom_range(0, 255);
					default: value = $urandom;
				endcase
				send_sample(value, 1'b0, '0);
				random_sent++;
			end
		end

		// Wait out the remaining averages, then watch for stray results.
		drain_averages();
		no_idle = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_averages.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d averages never arrived", pending_averages.size());
		end

		$display("Sent %0d samples under %0d register settings: %0d pass-through, %0d seeded,",
			samples_sent, settings_used, pass_through_count, seeded_count);
		$display("%0d weighted; %0d averages checked with %0d mismatches.",
			weighted_count, averages_checked, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
